### hw/rtl/can_payload_crc8_macros.svh
// Assertion macros shared by the CRC-8 block.
// Needs clk and rst_n in the scope of use.
`ifndef CAN_PAYLOAD_CRC8_MACROS_SVH
`define CAN_PAYLOAD_CRC8_MACROS_SVH

// Antecedent this cycle implies consequent next cycle.
`define CPCRC8_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpcrc8 next-cycle check failed");

// Antecedent implies consequent in the same cycle.
`define CPCRC8_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpcrc8 same-cycle check failed");

`endif

### hw/rtl/cpcrc8_pkg.sv
// Package for the CAN payload CRC-8 block: sizes, register indices,
// the stage payload type and the byte-wide CRC step. No dependencies.
package cpcrc8_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int DATA_BYTES  = ((FRAME_BYTES > 8) ? 8 : FRAME_BYTES) - 1;
    localparam int NUM_CELLS   = DATA_BYTES + 1;
    localparam int REST_W      = 8 * DATA_BYTES;
    localparam int PAYLOAD_W   = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_POLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD  = 2'd1;

    localparam logic [7:0] POLY_RESET = 8'h2F;
    localparam logic [7:0] PAD_RESET  = 8'hDA;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_XOROUT = 8'hFF;

    typedef struct packed {
        logic [7:0]        crc;
        logic [REST_W-1:0] rest;
    } stage_t;

    // Eight MSB-first shift steps.
    function automatic logic [7:0] crc_byte_step(input logic [7:0] r_in,
                                                 input logic [7:0] poly);
        logic [7:0] r;
        r = r_in;
        for (int k = 0; k < 8; k++) begin
            if (r[7])
                r = {r[6:0], 1'b0} ^ poly;
            else
                r = {r[6:0], 1'b0};
        end
        return r;
    endfunction

endpackage

### hw/rtl/cpcrc8_cell.sv
// One cell of the CRC row: folds one byte into the running CRC and hands
// the remaining bytes on. Depends on cpcrc8_pkg and the assertion macros.
`include "can_payload_crc8_macros.svh"

module cpcrc8_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          poly,
    input  logic                in_valid,
    output logic                in_ready,
    input  cpcrc8_pkg::stage_t  stage_in,
    input  logic [7:0]          byte_in,
    output logic                out_valid,
    input  logic                out_ready,
    output cpcrc8_pkg::stage_t  stage_out
);
    import cpcrc8_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    stage_t stage_reg;
    logic   load;

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg.crc  <= crc_byte_step(stage_in.crc ^ byte_in, poly);
            stage_reg.rest <= stage_in.rest >> 8;
        end
    end

    assign out_valid = valid_reg;
    assign stage_out = stage_reg;

    `CPCRC8_ASSERT_NEXT(a_load_sets_valid, load, valid_reg)
    `CPCRC8_ASSERT_NEXT(a_crc_step, load,
        stage_reg.crc == $past(crc_byte_step(stage_in.crc ^ byte_in, poly)))
    `CPCRC8_ASSERT_NEXT(a_stall_holds, valid_reg && !out_ready,
        valid_reg && $stable(stage_reg))

endmodule

### hw/rtl/can_payload_crc8.sv
// CAN payload CRC-8 (8H2F style) top level: configuration registers and the
// row of CRC cells. Depends on cpcrc8_pkg, cpcrc8_cell and the assertion macros.
//
// Usage:
//   Input channel in_valid/in_ready carries one 64-bit payload per request;
//   byte 0 (bits 7:0) is ignored, bytes 1..7 are folded in ascending order.
//   Output channel out_valid/out_ready returns crc_value, the check byte for
//   data byte 0.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 = poly,
//   1 = pad_byte); other indices are dropped. Write only while idle.
//   Pipeline: eight cells, one per data byte plus one for the padding byte;
//   the first cell loads at the accepting edge and out_valid rises once the
//   result has passed through all eight cells. Throughput: one request per
//   cycle while the output is not stalled; each cell is a register stage.
//   Stall: a cell holds its result while the next one is full and stalled;
//   empty cells further up keep accepting, so in_ready drops only once the
//   whole row is full. Ready runs combinationally back along the row.
//   Reset: all cells empty, poly = 0x2F, pad_byte = 0xDA.
//
module can_payload_crc8 (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cpcrc8_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cpcrc8_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cpcrc8_pkg::PAYLOAD_W-1:0]    payload,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          crc_value
);
    import cpcrc8_pkg::*;

    logic [7:0] poly_reg;
    logic [7:0] pad_reg;

    logic       link_valid [NUM_CELLS+1];
    logic       link_ready [NUM_CELLS+1];
    stage_t     link       [NUM_CELLS+1];
    logic [7:0] cell_byte  [NUM_CELLS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= POLY_RESET;
            pad_reg  <= PAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POLY: poly_reg <= cfg_data;
                REG_PAD:  pad_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign link_valid[0] = in_valid;
    assign in_ready      = link_ready[0];
    assign link[0].crc   = CRC_INIT;
    assign link[0].rest  = payload[8*DATA_BYTES+7:8];

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        if (k < DATA_BYTES)
        begin : g_data
            assign cell_byte[k] = link[k].rest[7:0];
        end
        else
        begin : g_pad
            assign cell_byte[k] = pad_reg;
        end

        cpcrc8_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .poly      (poly_reg),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .stage_in  (link[k]),
            .byte_in   (cell_byte[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .stage_out (link[k+1])
        );
    end

    assign link_ready[NUM_CELLS] = out_ready;
    assign out_valid             = link_valid[NUM_CELLS];
    assign crc_value             = link[NUM_CELLS].crc ^ CRC_XOROUT;

endmodule
